>>> src/srvt_pkg.sv
// Package for the sorted rate/voltage table: codes, fixed field widths,
// constants and the controller/datapath command and status structs.
// No dependencies.
package srvt_pkg;

	localparam logic [1:0] FUNC_PATCH   = 2'd0;
	localparam logic [1:0] FUNC_RD_VOLT = 2'd1;
	localparam logic [1:0] FUNC_RD_RATE = 2'd2;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_DELETED  = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_BAD_RATE = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_HIT      = 3'd5;
	localparam logic [2:0] ST_MISS     = 3'd6;

	localparam int RATE_W = 22;
	localparam int VOLT_W = 21;
	localparam int RND_W  = 23;

	localparam logic [VOLT_W-1:0] VOLT_MAX     = 21'h1F_FFFF;
	localparam logic [VOLT_W-1:0] OFFSET_LIMIT = 21'd10000;
	localparam logic [12:0]       STEP_UV      = 13'd6250;
	// floor(x / 6250) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^22
	localparam logic [22:0]       RECIP        = 23'd5497559;
	localparam int                RECIP_SHIFT  = 35;

	typedef struct packed {
		logic       latch;
		logic       scan_rd;
		logic       scan_next;
		logic       set_del;
		logic       set_ins;
		logic       rd_up;
		logic       rd_dn;
		logic       wr_up;
		logic       wr_dn;
		logic       wr_upd;
		logic       wr_new;
		logic       cnt_dec;
		logic       cnt_inc;
		logic       finish;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       dom_ok;
		logic       rate_zero;
		logic       volt_zero;
		logic       full;
		logic       scan_end;
		logic       cmp_stop;
		logic       cmp_eq;
		logic       del_done;
		logic       ins_done;
	} dp_sts_t;

endpackage

>>> src/sorted_rate_voltage_table.sv
// Top level of the sorted rate/voltage table: controller plus datapath.
// Depends on srvt_pkg, srvt_ctrl and srvt_dp.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  item in  | start & !busy       | func, domain, rate, volt, lookup_key
//  result   | done (one cycle)    | status, read_value, level_count
//
// An item scans its domain's table entry by entry, and a delete or insert then
// shifts the entries after its place one by one. done is raised in the cycle
// after the last busy cycle. The single-port entry memory, read and written one
// entry at a time, sets this pace.
// Reset clears the level counts and the controller; entries need no clearing.
// done is high one cycle; the next item may start in that same cycle.
module sorted_rate_voltage_table #(
	parameter int NUM_DOMAINS = 8,
	parameter int MAX_LEVELS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [2:0]  domain,
	input  logic [21:0] rate,
	input  logic [20:0] volt,
	input  logic [21:0] lookup_key,
	output logic        done,
	output logic [2:0]  status,
	output logic [21:0] read_value,
	output logic [5:0]  level_count
);

	srvt_pkg::dp_cmd_t cmd;
	srvt_pkg::dp_sts_t sts;

	srvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	srvt_dp #(
		.NUM_DOMAINS (NUM_DOMAINS),
		.MAX_LEVELS  (MAX_LEVELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.domain      (domain),
		.rate        (rate),
		.volt        (volt),
		.lookup_key  (lookup_key),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.level_count (level_count)
	);

endmodule

>>> src/srvt_ctrl.sv
// Controller state machine for the sorted rate/voltage table.
// Uses srvt_pkg; drives srvt_dp through dp_cmd_t and watches dp_sts_t.
module srvt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srvt_pkg::dp_sts_t sts,
	output srvt_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_P1, S_P2, S_P3, S_SCAN, S_CMP, S_UPD,
		S_DEL_RD, S_DEL_WR, S_INS_RD, S_INS_WR, S_FIN
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] st_q, st_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.st  = st_q;
		state_d = state_q;
		st_d    = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_P1;
				end
			end
			S_P1: state_d = S_P2;
			S_P2: state_d = S_P3;
			S_P3: begin
				if (!sts.dom_ok) begin
					st_d    = (sts.func == srvt_pkg::FUNC_PATCH) ?
						srvt_pkg::ST_BAD_RATE : srvt_pkg::ST_MISS;
					state_d = S_FIN;
				end else if (sts.func != srvt_pkg::FUNC_PATCH &&
						sts.func != srvt_pkg::FUNC_RD_VOLT &&
						sts.func != srvt_pkg::FUNC_RD_RATE) begin
					st_d    = srvt_pkg::ST_MISS;
					state_d = S_FIN;
				end else if (sts.func == srvt_pkg::FUNC_PATCH && sts.rate_zero) begin
					st_d    = srvt_pkg::ST_BAD_RATE;
					state_d = S_FIN;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					if (sts.func != srvt_pkg::FUNC_PATCH) begin
						st_d    = srvt_pkg::ST_MISS;
						state_d = S_FIN;
					end else if (sts.full) begin
						st_d    = srvt_pkg::ST_FULL;
						state_d = S_FIN;
					end else begin
						cmd.set_ins = 1'b1;
						state_d     = S_INS_RD;
					end
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.cmp_stop && sts.cmp_eq) begin
					if (sts.func != srvt_pkg::FUNC_PATCH) begin
						st_d    = srvt_pkg::ST_HIT;
						state_d = S_FIN;
					end else if (sts.volt_zero) begin
						cmd.set_del = 1'b1;
						state_d     = S_DEL_RD;
					end else begin
						state_d = S_UPD;
					end
				end else if (sts.cmp_stop) begin
					// passed the sorted place of the rate
					if (sts.func != srvt_pkg::FUNC_PATCH) begin
						st_d    = srvt_pkg::ST_MISS;
						state_d = S_FIN;
					end else if (sts.full) begin
						st_d    = srvt_pkg::ST_FULL;
						state_d = S_FIN;
					end else begin
						cmd.set_ins = 1'b1;
						state_d     = S_INS_RD;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_UPD: begin
				cmd.wr_upd = 1'b1;
				st_d       = srvt_pkg::ST_UPDATED;
				state_d    = S_FIN;
			end
			S_DEL_RD: begin
				if (sts.del_done) begin
					cmd.cnt_dec = 1'b1;
					st_d        = srvt_pkg::ST_DELETED;
					state_d     = S_FIN;
				end else begin
					cmd.rd_up = 1'b1;
					state_d   = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				cmd.wr_up = 1'b1;
				state_d   = S_DEL_RD;
			end
			S_INS_RD: begin
				if (sts.ins_done) begin
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					st_d        = srvt_pkg::ST_INSERTED;
					state_d     = S_FIN;
				end else begin
					cmd.rd_dn = 1'b1;
					state_d   = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_dn = 1'b1;
				state_d   = S_INS_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= srvt_pkg::ST_MISS;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

>>> src/srvt_dp.sv
// Datapath for the sorted rate/voltage table: item registers, step rounding,
// voltage arithmetic, entry memory, level counts and result registers.
// Uses srvt_pkg; commanded by srvt_ctrl.
module srvt_dp #(
	parameter int NUM_DOMAINS = 8,
	parameter int MAX_LEVELS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        func,
	input  logic [2:0]        domain,
	input  logic [21:0]       rate,
	input  logic [20:0]       volt,
	input  logic [21:0]       lookup_key,
	input  srvt_pkg::dp_cmd_t cmd,
	output srvt_pkg::dp_sts_t sts,
	output logic              done,
	output logic [2:0]        status,
	output logic [21:0]       read_value,
	output logic [5:0]        level_count
);

	localparam int NDE   = (NUM_DOMAINS < 8) ? NUM_DOMAINS : 8;
	localparam int DEPTH = NDE * MAX_LEVELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_LEVELS + 1);
	localparam int RW    = srvt_pkg::RATE_W;
	localparam int VW    = srvt_pkg::VOLT_W;
	localparam int XW    = srvt_pkg::RND_W;
	localparam int WW    = RW + VW;

	logic [1:0]    func_q;
	logic [2:0]    dom_q;
	logic [RW-1:0] rate_q, key_q;
	logic [VW-1:0] volt_q;
	logic          dom_ok_q;
	logic [CW-1:0] n_q, j_q, k_q;
	logic [CW-1:0] cnt_q [NDE];

	logic [2*XW-1:0] prod_q;
	logic [XW-1:0]   qm_q, want_q;
	logic [26:0]     off_q;

	logic [WW-1:0] mem_q [DEPTH];
	logic [WW-1:0] rd_q;

	logic          done_q;
	logic [2:0]    status_q;
	logic [RW-1:0] read_value_q;
	logic [5:0]    level_count_q;

	logic          dom_ok_in;
	logic [XW-1:0] x;
	logic [RW-1:0] target, rd_rate;
	logic [VW-1:0] rd_volt, base, absv, offv, newv;
	logic [27:0]   sum;
	logic [10:0]   quo;
	logic          rd_en, wr_en;
	logic [CW-1:0] rd_idx, wr_idx;
	logic [WW-1:0] wr_data;

	function automatic logic [AW-1:0] addr_of(input logic [2:0] d, input logic [CW-1:0] i);
		addr_of = AW'(AW'(d) * AW'(MAX_LEVELS) + AW'(i));
	endfunction

	assign dom_ok_in = (int'(domain) < NUM_DOMAINS);
	assign x       = (func_q == srvt_pkg::FUNC_PATCH) ? XW'(volt_q) : XW'(key_q);
	assign target  = (func_q == srvt_pkg::FUNC_PATCH) ? rate_q : key_q;
	assign rd_rate = rd_q[WW-1:VW];
	assign rd_volt = rd_q[VW-1:0];
	assign quo     = prod_q[2*XW-1:srvt_pkg::RECIP_SHIFT];

	// new voltage: absolute (rounded) or base plus step offset, saturated
	assign base = cmd.wr_upd ? rd_volt : '0;
	assign sum  = 28'(base) + 28'(off_q);
	assign offv = (sum > 28'(srvt_pkg::VOLT_MAX)) ? srvt_pkg::VOLT_MAX : sum[VW-1:0];
	assign absv = (want_q > XW'(srvt_pkg::VOLT_MAX)) ? srvt_pkg::VOLT_MAX : want_q[VW-1:0];
	assign newv = (volt_q > srvt_pkg::OFFSET_LIMIT) ? absv : offv;

	assign rd_en  = cmd.scan_rd | cmd.rd_up | cmd.rd_dn;
	assign rd_idx = cmd.scan_rd ? j_q : (cmd.rd_up ? CW'(k_q + 1'b1) : CW'(k_q - 1'b1));
	assign wr_en  = cmd.wr_upd | cmd.wr_new | cmd.wr_up | cmd.wr_dn;
	assign wr_idx = (cmd.wr_upd | cmd.wr_new) ? j_q : k_q;
	always_comb begin
		if (cmd.wr_upd)
			wr_data = {rd_rate, newv};
		else if (cmd.wr_new)
			wr_data = {rate_q, newv};
		else
			wr_data = rd_q;
	end

	always_comb begin
		sts           = '0;
		sts.func      = func_q;
		sts.dom_ok    = dom_ok_q;
		sts.rate_zero = (rate_q == '0);
		sts.volt_zero = (volt_q == '0);
		sts.full      = (n_q >= CW'(MAX_LEVELS));
		sts.scan_end  = (j_q == n_q);
		if (func_q == srvt_pkg::FUNC_RD_RATE) begin
			sts.cmp_stop = (want_q == XW'(rd_volt));
			sts.cmp_eq   = sts.cmp_stop;
		end else begin
			// tables are kept in strictly descending rate order
			sts.cmp_stop = (rd_rate <= target);
			sts.cmp_eq   = (rd_rate == target);
		end
		sts.del_done = ((CW + 1)'(k_q) + 1'b1 >= (CW + 1)'(n_q));
		sts.ins_done = (k_q == j_q);
	end

	// item registers and step rounding; the rounding pipe refills every cycle
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			dom_q  <= domain;
			rate_q <= rate;
			volt_q <= volt;
			key_q  <= lookup_key;
		end
		prod_q <= (2 * XW)'(x) * (2 * XW)'(srvt_pkg::RECIP);
		qm_q   <= XW'(XW'(quo) * XW'(srvt_pkg::STEP_UV));
		want_q <= (x == qm_q) ? x : XW'(qm_q + XW'(srvt_pkg::STEP_UV));
		off_q  <= 27'(volt_q[13:0]) * 27'(srvt_pkg::STEP_UV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dom_ok_q <= 1'b0;
			n_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			for (int i = 0; i < NDE; i++)
				cnt_q[i] <= '0;
		end else begin
			if (cmd.latch) begin
				dom_ok_q <= dom_ok_in;
				n_q      <= dom_ok_in ? cnt_q[domain] : '0;
				j_q      <= '0;
			end
			if (cmd.scan_next)
				j_q <= CW'(j_q + 1'b1);
			if (cmd.set_del)
				k_q <= j_q;
			if (cmd.set_ins)
				k_q <= n_q;
			if (cmd.wr_up)
				k_q <= CW'(k_q + 1'b1);
			if (cmd.wr_dn)
				k_q <= CW'(k_q - 1'b1);
			if (cmd.cnt_dec) begin
				n_q           <= CW'(n_q - 1'b1);
				cnt_q[dom_q]  <= CW'(n_q - 1'b1);
			end
			if (cmd.cnt_inc) begin
				n_q           <= CW'(n_q + 1'b1);
				cnt_q[dom_q]  <= CW'(n_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem_q[addr_of(dom_q, rd_idx)];
		if (wr_en)
			mem_q[addr_of(dom_q, wr_idx)] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.finish;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q      <= cmd.st;
			level_count_q <= 6'(n_q);
			if (cmd.st != srvt_pkg::ST_HIT)
				read_value_q <= '0;
			else if (func_q == srvt_pkg::FUNC_RD_RATE)
				read_value_q <= rd_rate;
			else
				read_value_q <= RW'(rd_volt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign level_count = level_count_q;

endmodule

>>> tb/sv/tb_sorted_rate_voltage_table.sv
// Testbench for sorted_rate_voltage_table: directed table plus random beats; each
// result is checked against its typed reply or an in-bench model of the domain tables.
// Depends on srvt_pkg and the RTL of sorted_rate_voltage_table.
`timescale 1ns / 100ps

module tb_sorted_rate_voltage_table;

	localparam int DOMS = 8;
	localparam int LEVELS = 32;
	localparam int RANDOM_BEATS = 1700;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [2:0]  st;
		logic [21:0] val;
		logic [5:0]  cnt;
	} table_reply_t;

	typedef struct {
		logic [1:0]   fn;
		logic [2:0]   dom;
		logic [21:0]  rt;
		logic [20:0]  vt;
		logic [21:0]  key;
		bit           typed;
		table_reply_t want;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [2:0]  domain;
	logic [21:0] rate;
	logic [20:0] volt;
	logic [21:0] lookup_key;
	logic        done;
	logic [2:0]  status;
	logic [21:0] read_value;
	logic [5:0]  level_count;

	// model of the domain tables
	logic [21:0] lvl_rate[DOMS][LEVELS];
	logic [20:0] lvl_volt[DOMS][LEVELS];
	int          lvl_cnt[DOMS];

	table_reply_t pending_replies[$];
	table_row_t   directed_rows[$];
	int           errors = 0;
	int           stall_cycles = 0;

	sorted_rate_voltage_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .domain(domain), .rate(rate), .volt(volt),
		.lookup_key(lookup_key), .done(done), .status(status),
		.read_value(read_value), .level_count(level_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint step_round(longint v);
		longint r;
		r = v % 6250;
		return (r != 0) ? v + 6250 - r : v;
	endfunction

	function automatic logic [20:0] new_voltage(logic [20:0] cur, logic [20:0] v);
		longint s;
		if (v > srvt_pkg::OFFSET_LIMIT) s = step_round(v);
		else s = longint'(cur) + longint'(v) * 6250;
		return (s > srvt_pkg::VOLT_MAX) ? srvt_pkg::VOLT_MAX : s[20:0];
	endfunction

	// applies one beat to the table model and returns the reply it causes
	function automatic table_reply_t table_apply(logic [1:0] fn, logic [2:0] d,
			logic [21:0] rt, logic [20:0] vt, logic [21:0] key);
		table_reply_t r;
		int n, j, k;
		longint want;
		r.st = srvt_pkg::ST_MISS;
		r.val = '0;
		n = lvl_cnt[d];
		if (fn == srvt_pkg::FUNC_PATCH) begin
			if (rt == 0) begin
				r.st = srvt_pkg::ST_BAD_RATE;
			end else begin
				for (j = 0; j < n; j++)
					if (lvl_rate[d][j] == rt) break;
				if (j < n) begin
					if (vt != 0) begin
						lvl_volt[d][j] = new_voltage(lvl_volt[d][j], vt);
						r.st = srvt_pkg::ST_UPDATED;
					end else begin
						for (k = j; k + 1 < n; k++) begin
							lvl_rate[d][k] = lvl_rate[d][k+1];
							lvl_volt[d][k] = lvl_volt[d][k+1];
						end
						n--;
						r.st = srvt_pkg::ST_DELETED;
					end
				end else if (n >= LEVELS) begin
					r.st = srvt_pkg::ST_FULL;
				end else begin
					for (j = 0; j < n; j++)
						if (lvl_rate[d][j] < rt) break;
					for (k = n; k > j; k--) begin
						lvl_rate[d][k] = lvl_rate[d][k-1];
						lvl_volt[d][k] = lvl_volt[d][k-1];
					end
					lvl_rate[d][j] = rt;
					lvl_volt[d][j] = (vt != 0) ? new_voltage('0, vt) : '0;
					n++;
					r.st = srvt_pkg::ST_INSERTED;
				end
				lvl_cnt[d] = n;
			end
		end else if (fn == srvt_pkg::FUNC_RD_VOLT) begin
			for (j = 0; j < n; j++)
				if (lvl_rate[d][j] == key) begin
					r.st = srvt_pkg::ST_HIT;
					r.val = 22'(lvl_volt[d][j]);
					break;
				end
		end else if (fn == srvt_pkg::FUNC_RD_RATE) begin
			want = step_round(key);
			for (j = 0; j < n; j++)
				if (longint'(lvl_volt[d][j]) == want) begin
					r.st = srvt_pkg::ST_HIT;
					r.val = lvl_rate[d][j];
					break;
				end
		end
		r.cnt = 6'(n);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_beat(table_row_t row);
		table_reply_t r;
		func <= row.fn;
		domain <= row.dom;
		rate <= row.rt;
		volt <= row.vt;
		lookup_key <= row.key;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = table_apply(row.fn, row.dom, row.rt, row.vt, row.key);
		pending_replies.push_back(row.typed ? row.want : r);
		@(negedge clk);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	function automatic table_row_t random_row();
		table_row_t row;
		int sel, n;
		row.typed = 0;
		row.want = '{default: '0};
		row.dom = 3'($urandom_range(0, DOMS - 1));
		n = lvl_cnt[row.dom];
		row.rt = 22'($urandom);
		row.vt = 21'($urandom);
		row.key = 22'($urandom);
		sel = $urandom_range(0, 99);
		// low domains use a small rate pool so they fill up and hit often
		if (row.dom < 4 && sel < 90) row.rt = 22'($urandom_range(1, 40));
		if (sel < 55) begin
			row.fn = srvt_pkg::FUNC_PATCH;
			case ($urandom_range(0, 9))
				0, 1: row.vt = '0;
				2, 3, 4: row.vt = 21'($urandom_range(1, 20));
				5: row.vt = 21'($urandom_range(1, 10000));
				6: row.vt = 21'($urandom_range(10001, 2000000));
				7: row.rt = (n > 0) ? lvl_rate[row.dom][$urandom_range(0, n - 1)] : row.rt;
				8: row.rt = ($urandom_range(0, 3) == 0) ? '0 : row.rt;
				default: ;
			endcase
		end else if (sel < 75) begin
			row.fn = srvt_pkg::FUNC_RD_VOLT;
			if (n > 0 && $urandom_range(0, 3) != 0)
				row.key = lvl_rate[row.dom][$urandom_range(0, n - 1)];
		end else if (sel < 95) begin
			row.fn = srvt_pkg::FUNC_RD_RATE;
			if (n > 0 && $urandom_range(0, 3) != 0) begin
				row.key = 22'(lvl_volt[row.dom][$urandom_range(0, n - 1)]);
				if (row.key >= 6250) row.key = row.key - 22'($urandom_range(0, 6249));
			end
		end else begin
			row.fn = FUNC_UNUSED;
		end
		return row;
	endfunction

	always @(posedge clk) begin
		table_reply_t w;
		if (done) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result st=%0d val=%0d cnt=%0d",
					$time, status, read_value, level_count);
				errors++;
			end else begin
				w = pending_replies.pop_front();
				if (status !== w.st) begin
					$display("%0t: status exp %0d got %0d", $time, w.st, status);
					errors++;
				end
				if (read_value !== w.val) begin
					$display("%0t: read_value exp %0d got %0d", $time, w.val, read_value);
					errors++;
				end
				if (level_count !== w.cnt) begin
					$display("%0t: level_count exp %0d got %0d", $time, w.cnt, level_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic table_row_t row(logic [1:0] fn, logic [2:0] d, logic [21:0] rt,
			logic [20:0] vt, logic [21:0] key, bit typed = 0,
			logic [2:0] st = '0, logic [21:0] val = '0, logic [5:0] cnt = '0);
		table_row_t t;
		t.fn = fn; t.dom = d; t.rt = rt; t.vt = vt; t.key = key;
		t.typed = typed;
		t.want.st = st; t.want.val = val; t.want.cnt = cnt;
		return t;
	endfunction

	initial begin
		table_row_t rw;
		for (int d = 0; d < DOMS; d++) lvl_cnt[d] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = srvt_pkg::FUNC_PATCH;
		domain = '0;
		rate = '0;
		volt = '0;
		lookup_key = '0;

		// empty table, zero rate, unused func, extremes, saturation, delete of absent
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_VOLT, 0, 0, 0, 5, 1,
			srvt_pkg::ST_MISS, 0, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 0, 21'd500, 0, 1,
			srvt_pkg::ST_BAD_RATE, 0, 0));
		directed_rows.push_back(row(FUNC_UNUSED, 0, 22'h3FFFFF, 21'h1FFFFF, 22'h3FFFFF,
			1, srvt_pkg::ST_MISS, 0, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 22'h3FFFFF,
			srvt_pkg::VOLT_MAX, 0, 1, srvt_pkg::ST_INSERTED, 0, 1));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_VOLT, 0, 0, 0, 22'h3FFFFF,
			1, srvt_pkg::ST_HIT, 22'(srvt_pkg::VOLT_MAX), 1));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 22'h3FFFFF, 21'd10000, 0,
			1, srvt_pkg::ST_UPDATED, 0, 1));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 1, 0, 0, 1,
			srvt_pkg::ST_INSERTED, 0, 2));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 1, 21'd10001, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 1, 21'd3, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_RATE, 0, 0, 0, 22'd31249));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 22'd500, 21'd6250, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_RATE, 0, 0, 0, 22'd2097151));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_RATE, 0, 0, 0, 22'd6250));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 1, 0, 0, 1,
			srvt_pkg::ST_DELETED, 0, 2));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 7, 22'd7, 21'd1, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_VOLT, 7, 0, 0, 22'd7));
		directed_rows.push_back(row(srvt_pkg::FUNC_PATCH, 0, 22'h3FFFFF, 0, 0));
		directed_rows.push_back(row(srvt_pkg::FUNC_RD_VOLT, 0, 0, 0, 22'h3FFFFF));

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i]);
			if ($urandom_range(0, 2) == 0) idle_burst();
		end

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 3) begin
				// drain fully before continuing
				start <= 1'b0;
				while (pending_replies.size() != 0) @(negedge clk);
			end
			rw = random_row();
			send_beat(rw);
			if (i < RANDOM_BEATS - 300 && $urandom_range(0, 3) == 0) idle_burst();
		end
		start <= 1'b0;

		while (pending_replies.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
